[rtl/ssem_pkg.sv]
// Shared types and constants of the segmented shunt energy meter.
package ssem_pkg;

  localparam int unsigned OpW    = 64;
  localparam int unsigned ProdW  = 128;
  localparam int unsigned DvdW   = 48;
  localparam int unsigned DsrW   = 24;
  localparam int unsigned IterW  = 6;

  localparam logic [1:0] RegPlusGain  = 2'd0;
  localparam logic [1:0] RegMinusGain = 2'd1;
  localparam logic [1:0] RegShunt     = 2'd2;

  localparam logic [17:0] PlusGainReset  = 18'd69475;
  localparam logic [17:0] MinusGainReset = 18'd69304;
  localparam logic [15:0] ShuntReset     = 16'd120;

  localparam logic [63:0]    MilliScale  = 64'd1000;
  localparam logic [23:0]    CountMax    = 24'hFFFFFF;

  // Divide by 4000000: drop 8 bits, then multiply by ceil(2^75 / 15625) and keep bits from 75.
  localparam logic [63:0] EnergyRecip  = 64'd2417851639229258350;
  localparam logic [60:0] EnergySatLim = 61'd2199023255552000000;

  typedef struct packed {
    logic            start;
    logic [OpW-1:0]  a;
    logic [OpW-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DvdW-1:0]  dividend;
    logic [DsrW-1:0]  divisor;
    logic [IterW-1:0] iters;
  } div_req_t;

endpackage

[rtl/ssem_mul.sv]
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier over four passes.
module ssem_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  ssem_pkg::mul_req_t         req,
  output logic                       done,
  output logic [ssem_pkg::ProdW-1:0] prod
);

  logic                      busy;
  logic [2:0]                cnt;
  logic [ssem_pkg::OpW-1:0]  a_r;
  logic [ssem_pkg::OpW-1:0]  b_r;
  logic [63:0]               pp;
  logic [1:0]                pp_sh;
  logic [31:0]               ai;
  logic [31:0]               bi;

  assign ai = cnt[0] ? a_r[63:32] : a_r[31:0];
  assign bi = cnt[1] ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b;
      prod <= '0;
    end else if (busy) begin
      pp    <= ai * bi;
      pp_sh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
      if (cnt != 3'd0) begin
        prod <= prod + ({64'd0, pp} << {pp_sh, 5'd0});
      end
    end
  end

endmodule

[rtl/ssem_div.sv]
// Shared restoring divider, one quotient bit per cycle on a left-aligned dividend.
module ssem_div (
  input  logic                      clk,
  input  logic                      rst,
  input  ssem_pkg::div_req_t        req,
  output logic                      done,
  output logic [ssem_pkg::DvdW-1:0] quo
);

  logic                       busy;
  logic [ssem_pkg::IterW-1:0] cnt;
  logic [ssem_pkg::DsrW-1:0]  d_r;
  logic [ssem_pkg::DsrW-1:0]  rem;
  logic [ssem_pkg::DsrW:0]    t;
  logic [ssem_pkg::DsrW:0]    t_sub;
  logic                       ge;

  assign t     = {rem, quo[ssem_pkg::DvdW-1]};
  assign ge    = t >= {1'b0, d_r};
  assign t_sub = t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      d_r <= req.divisor;
    end else if (busy) begin
      rem <= ge ? t_sub[ssem_pkg::DsrW-1:0] : t[ssem_pkg::DsrW-1:0];
      quo <= {quo[ssem_pkg::DvdW-2:0], ge};
    end
  end

endmodule

[rtl/segmented_shunt_energy_meter_top.sv]
// Segmented shunt energy meter: sequencer, stream state and result register.
// One request in flight; in_stall drops when the last result of a request loads. Seven
// multiplies on the shared 32x32 unit and two bit-serial divides (38 and 48 steps) set the
// time. Reset (rst, synchronous) clears the stream state and out_valid and loads the
// configuration registers with their reset values.
module segmented_shunt_energy_meter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [39:0] stamp_ms,
  input  logic [24:0] plus_uv,
  input  logic [24:0] minus_uv,
  input  logic [7:0]  tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [39:0] time_ms,
  output logic [31:0] current_ua,
  output logic [47:0] energy_nj,
  output logic [47:0] charge_ua_ms,
  output logic [7:0]  seg_tag,
  output logic        last
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_G1 = 5'd1,  S_G1W = 5'd2,  S_G2 = 5'd3;
  localparam logic [4:0] S_G2W  = 5'd4,  S_K  = 5'd5,  S_KW  = 5'd6,  S_CD = 5'd7;
  localparam logic [4:0] S_CDW  = 5'd8,  S_A  = 5'd9,  S_AW  = 5'd10, S_E  = 5'd11;
  localparam logic [4:0] S_EW   = 5'd12, S_ED = 5'd13, S_EDW = 5'd14, S_Q  = 5'd15;
  localparam logic [4:0] S_QW   = 5'd16, S_AV = 5'd17, S_AVW = 5'd18, S_EC = 5'd19;
  localparam logic [4:0] S_ES   = 5'd20;

  function automatic logic [31:0] sat32(input logic [47:0] m, input logic neg);
    logic [47:0] n;
    n = ~m + 48'd1;
    if (!neg) sat32 = (m > 48'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    else      sat32 = (m > 48'h80000000) ? 32'h80000000 : n[31:0];
  endfunction

  function automatic logic [47:0] sat48(input logic [79:0] m, input logic neg);
    logic [47:0] n;
    n = ~m[47:0] + 48'd1;
    if (|m[79:47]) sat48 = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    else           sat48 = neg ? n : m[47:0];
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) add48 = s[48] ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    else                add48 = s[47:0];
  endfunction

  logic [4:0]  state;
  logic [17:0] plus_gain;
  logic [17:0] minus_gain;
  logic [15:0] shunt;

  logic        mode_r;
  logic [39:0] stamp_r;
  logic [24:0] puv_r;
  logic [24:0] muv_r;
  logic [7:0]  tag_r;

  logic [26:0] pg;
  logic [26:0] mg;
  logic [31:0] cur;
  logic [63:0] a_mag;
  logic        a_neg;
  logic        e_sat;
  logic [47:0] e_inc;
  logic [47:0] q_inc;
  logic [31:0] avg;

  logic        seen_first;
  logic [39:0] base_stamp;
  logic [39:0] prev_stamp;
  logic [31:0] prev_current;
  logic [26:0] prev_load;
  logic [7:0]  open_tag;
  logic [39:0] seg_start;
  logic [47:0] seg_cur_sum;
  logic [47:0] seg_e_sum;
  logic [47:0] seg_q_sum;
  logic [23:0] seg_count;

  ssem_pkg::mul_req_t         mreq;
  ssem_pkg::div_req_t         dreq;
  logic                       mdone;
  logic                       ddone;
  logic [ssem_pkg::ProdW-1:0] prod;
  logic [ssem_pkg::DvdW-1:0]  dquo;

  logic [24:0] puv_mag;
  logic [24:0] muv_mag;
  logic [26:0] gain_m;
  logic [26:0] gain_n;
  logic [27:0] diff;
  logic [27:0] diff_mag;
  logic [32:0] isum;
  logic [32:0] isum_mag;
  logic [27:0] vsum;
  logic [27:0] vsum_mag;
  logic [40:0] dt;
  logic [40:0] dt_mag;
  logic [47:0] sum_mag;
  logic [15:0] sh_eff;
  logic [39:0] rel;
  logic        new_seg;
  logic        slot_free;
  logic        accept;
  logic        e_sat_now;

  assign puv_mag  = puv_r[24] ? (~puv_r + 25'd1) : puv_r;
  assign muv_mag  = muv_r[24] ? (~muv_r + 25'd1) : muv_r;
  assign gain_m   = {1'b0, prod[41:16]};
  assign gain_n   = ~gain_m + 27'd1;
  assign diff     = {pg[26], pg} - {mg[26], mg};
  assign diff_mag = diff[27] ? (~diff + 28'd1) : diff;
  assign isum     = {cur[31], cur} + {prev_current[31], prev_current};
  assign isum_mag = isum[32] ? (~isum + 33'd1) : isum;
  assign vsum     = {mg[26], mg} + {prev_load[26], prev_load};
  assign vsum_mag = vsum[27] ? (~vsum + 28'd1) : vsum;
  assign dt       = {1'b0, stamp_r} - {1'b0, prev_stamp};
  assign dt_mag   = dt[40] ? (~dt + 41'd1) : dt;
  assign sum_mag  = seg_cur_sum[47] ? (~seg_cur_sum + 48'd1) : seg_cur_sum;
  assign sh_eff   = (shunt == 16'd0) ? 16'd1 : shunt;
  assign rel      = seen_first ? (stamp_r - base_stamp) : 40'd0;
  assign new_seg  = !seen_first || (tag_r != open_tag);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign e_sat_now = (|prod[100:69]) || (prod[68:8] >= ssem_pkg::EnergySatLim);

  ssem_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(prod));
  ssem_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(dquo));

  always_comb begin
    mreq = '0;
    dreq = '0;
    unique case (state)
      S_G1: begin
        mreq.start = 1'b1;
        mreq.a     = {39'd0, puv_mag};
        mreq.b     = {46'd0, plus_gain};
      end
      S_G2: begin
        mreq.start = 1'b1;
        mreq.a     = {39'd0, muv_mag};
        mreq.b     = {46'd0, minus_gain};
      end
      S_K: begin
        mreq.start = 1'b1;
        mreq.a     = {36'd0, diff_mag};
        mreq.b     = ssem_pkg::MilliScale;
      end
      S_CD: begin
        dreq.start    = 1'b1;
        dreq.dividend = {prod[37:0], 10'd0};
        dreq.divisor  = {8'd0, sh_eff};
        dreq.iters    = 6'd38;
      end
      S_A: begin
        mreq.start = 1'b1;
        mreq.a     = {31'd0, isum_mag};
        mreq.b     = {36'd0, vsum_mag};
      end
      S_E: begin
        mreq.start = 1'b1;
        mreq.a     = a_mag;
        mreq.b     = {23'd0, dt_mag};
      end
      S_ED: begin
        mreq.start = 1'b1;
        mreq.a     = {3'd0, prod[68:8]};
        mreq.b     = ssem_pkg::EnergyRecip;
      end
      S_Q: begin
        mreq.start = 1'b1;
        mreq.a     = {31'd0, isum_mag};
        mreq.b     = {23'd0, dt_mag};
      end
      S_AV: begin
        dreq.start    = 1'b1;
        dreq.dividend = sum_mag;
        dreq.divisor  = seg_count;
        dreq.iters    = 6'd48;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_gain  <= ssem_pkg::PlusGainReset;
      minus_gain <= ssem_pkg::MinusGainReset;
      shunt      <= ssem_pkg::ShuntReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssem_pkg::RegPlusGain:  plus_gain  <= cfg_data;
        ssem_pkg::RegMinusGain: minus_gain <= cfg_data;
        ssem_pkg::RegShunt:     shunt      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= mode;
      stamp_r <= stamp_ms;
      puv_r   <= plus_uv;
      muv_r   <= minus_uv;
      tag_r   <= tag;
    end
    if (state == S_G1W && mdone) pg <= puv_r[24] ? gain_n : gain_m;
    if (state == S_G2W && mdone) mg <= muv_r[24] ? gain_n : gain_m;
    if (state == S_CDW && ddone) begin
      cur   <= sat32({10'd0, dquo[37:0]}, diff[27]);
      e_inc <= '0;
      q_inc <= '0;
    end
    if (state == S_AW && mdone) begin
      a_mag <= prod[63:0];
      a_neg <= isum[32] ^ vsum[27];
    end
    if (state == S_ED) e_sat <= e_sat_now;
    if (state == S_EDW && mdone) e_inc <= sat48({31'd0, e_sat, prod[122:75]}, a_neg ^ dt[40]);
    if (state == S_QW && mdone) q_inc <= sat48(prod[80:1] | {79'd0, |prod[127:81]} << 79,
                                               isum[32] ^ dt[40]);
    if (state == S_AVW && ddone) avg <= sat32(dquo[47:0], seg_cur_sum[47]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      seen_first   <= 1'b0;
      base_stamp   <= '0;
      prev_stamp   <= '0;
      prev_current <= '0;
      prev_load    <= '0;
      open_tag     <= '0;
      seg_start    <= '0;
      seg_cur_sum  <= '0;
      seg_e_sum    <= '0;
      seg_q_sum    <= '0;
      seg_count    <= '0;
    end else begin
      if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          if (!mode) state <= S_G1;
          else if (seen_first) state <= S_AV;
        end
        S_G1:  state <= S_G1W;
        S_G1W: if (mdone) state <= S_G2;
        S_G2:  state <= S_G2W;
        S_G2W: if (mdone) state <= S_K;
        S_K:   state <= S_KW;
        S_KW:  if (mdone) state <= S_CD;
        S_CD:  state <= S_CDW;
        S_CDW: if (ddone) state <= seen_first ? S_A : S_ES;
        S_A:   state <= S_AW;
        S_AW:  if (mdone) state <= S_E;
        S_E:   state <= S_EW;
        S_EW:  if (mdone) state <= S_ED;
        S_ED:  state <= S_EDW;
        S_EDW: if (mdone) state <= S_Q;
        S_Q:   state <= S_QW;
        S_QW:  if (mdone) state <= (tag_r != open_tag) ? S_AV : S_ES;
        S_AV:  state <= S_AVW;
        S_AVW: if (ddone) state <= S_EC;
        S_EC: if (slot_free) begin
          out_valid <= 1'b1;
          if (mode_r) begin
            state        <= S_IDLE;
            seen_first   <= 1'b0;
            base_stamp   <= '0;
            prev_stamp   <= '0;
            prev_current <= '0;
            prev_load    <= '0;
            open_tag     <= '0;
            seg_start    <= '0;
            seg_cur_sum  <= '0;
            seg_e_sum    <= '0;
            seg_q_sum    <= '0;
            seg_count    <= '0;
          end else begin
            state <= S_ES;
          end
        end
        S_ES: if (slot_free) begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
          if (!seen_first) base_stamp <= stamp_r;
          if (new_seg) begin
            open_tag    <= tag_r;
            seg_start   <= rel;
            seg_cur_sum <= {{16{cur[31]}}, cur};
            seg_e_sum   <= e_inc;
            seg_q_sum   <= q_inc;
            seg_count   <= 24'd1;
          end else begin
            seg_cur_sum <= add48(seg_cur_sum, {{16{cur[31]}}, cur});
            seg_e_sum   <= add48(seg_e_sum, e_inc);
            seg_q_sum   <= add48(seg_q_sum, q_inc);
            if (seg_count != ssem_pkg::CountMax) seg_count <= seg_count + 24'd1;
          end
          prev_stamp   <= stamp_r;
          prev_current <= cur;
          prev_load    <= mg;
          seen_first   <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EC && slot_free) begin
      kind         <= 1'b1;
      time_ms      <= seg_start;
      current_ua   <= avg;
      energy_nj    <= seg_e_sum;
      charge_ua_ms <= seg_q_sum;
      seg_tag      <= open_tag;
      last         <= mode_r;
    end else if (state == S_ES && slot_free) begin
      kind         <= 1'b0;
      time_ms      <= rel;
      current_ua   <= cur;
      energy_nj    <= e_inc;
      charge_ua_ms <= q_inc;
      seg_tag      <= tag_r;
      last         <= 1'b1;
    end
  end

endmodule

[rtl/ssem_check.sv]
// Port-level checks of the segmented shunt energy meter, bound to its top level.
module ssem_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic mode,
  input logic out_valid,
  input logic out_stall,
  input logic kind,
  input logic last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_sample_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> last)
    else $error("sample result without last");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode |=> in_stall)
    else $error("request taken while a sample is in work");

endmodule

bind segmented_shunt_energy_meter_top ssem_check u_ssem_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
  .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .last(last)
);

[tb/tb_segmented_shunt_energy_meter_top.sv]
// Self-checking testbench of the segmented shunt energy meter, with a result scoreboard.
`timescale 1ns / 1ps

module tb_segmented_shunt_energy_meter_top;

  localparam logic ModeSample = 1'b0;
  localparam logic ModeEnd    = 1'b1;
  localparam logic KindSample = 1'b0;
  localparam logic KindClose  = 1'b1;
  localparam longint Max48    = 64'sd140737488355327;
  localparam longint Max32    = 64'sd2147483647;
  localparam int IdleCycles   = 400;

  typedef struct packed {
    logic        kind;
    logic [39:0] time_ms;
    logic [31:0] current_ua;
    logic [47:0] energy_nj;
    logic [47:0] charge_ua_ms;
    logic [7:0]  seg_tag;
    logic        last;
  } meter_result_t;

  class meter_scoreboard;
    longint unsigned plus_gain, minus_gain, shunt;
    bit              seen_first;
    logic [39:0]     base_stamp, prev_stamp, seg_start;
    longint          prev_cur, prev_load, seg_cur, seg_energy, seg_charge;
    logic [7:0]      open_tag;
    longint unsigned seg_count;
    meter_result_t   pending[$];
    int              errors, results, closes, requests;

    function new();
      plus_gain = ssem_pkg::PlusGainReset;
      minus_gain = ssem_pkg::MinusGainReset;
      shunt = ssem_pkg::ShuntReset;
      clear_stream();
    endfunction

    function void clear_stream();
      seen_first = 0;
      base_stamp = '0;
      prev_stamp = '0;
      seg_start = '0;
      prev_cur = 0;
      prev_load = 0;
      seg_cur = 0;
      seg_energy = 0;
      seg_charge = 0;
      open_tag = '0;
      seg_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [17:0] val);
      case (idx)
        ssem_pkg::RegPlusGain:  plus_gain = val;
        ssem_pkg::RegMinusGain: minus_gain = val;
        ssem_pkg::RegShunt:     shunt = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint x, longint hi);
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    function longint unsigned magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function longint scaled_product(longint unsigned a, longint unsigned b,
                                    longint unsigned d, bit neg);
      logic [127:0] quo;
      quo = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
      if (quo >= (128'd1 << 47)) return neg ? -Max48 - 1 : Max48;
      return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function longint corrected(logic [24:0] uv, longint unsigned g);
      longint v;
      longint unsigned m;
      v = {{39{uv[24]}}, uv};
      m = magnitude(v) * g / 65536;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function meter_result_t close_result(logic last);
      meter_result_t r;
      longint unsigned n;
      n = seg_count ? seg_count : 1;
      r.kind = KindClose;
      r.time_ms = seg_start;
      r.current_ua = 32'(clamp(seg_cur / longint'(n), Max32));
      r.energy_nj = 48'(seg_energy);
      r.charge_ua_ms = 48'(seg_charge);
      r.seg_tag = open_tag;
      r.last = last;
      closes++;
      return r;
    endfunction

    function void note_request(logic mode, logic [39:0] stamp, logic [24:0] puv,
                               logic [24:0] muv, logic [7:0] tg);
      longint pg, mg, cur, e, q, dt, isum, a;
      longint unsigned sh;
      logic [39:0] rel;
      meter_result_t r;
      requests++;
      e = 0;
      q = 0;
      if (mode == ModeEnd) begin
        if (!seen_first) return;
        pending.push_back(close_result(1'b1));
        clear_stream();
        return;
      end
      pg = corrected(puv, plus_gain);
      mg = corrected(muv, minus_gain);
      sh = shunt ? shunt : 1;
      cur = clamp((pg - mg) * 1000 / longint'(sh), Max32);
      if (!seen_first) begin
        base_stamp = stamp;
        rel = '0;
      end else begin
        dt = longint'({24'd0, stamp}) - longint'({24'd0, prev_stamp});
        isum = cur + prev_cur;
        a = isum * (mg + prev_load);
        rel = stamp - base_stamp;
        e = scaled_product(magnitude(a), magnitude(dt), 4000000, (a < 0) != (dt < 0));
        q = scaled_product(magnitude(isum), magnitude(dt), 2, (isum < 0) != (dt < 0));
      end
      if (!seen_first || tg != open_tag) begin
        if (seen_first) pending.push_back(close_result(1'b0));
        open_tag = tg;
        seg_start = rel;
        seg_cur = cur;
        seg_energy = e;
        seg_charge = q;
        seg_count = 1;
      end else begin
        seg_cur = clamp(seg_cur + cur, Max48);
        seg_energy = clamp(seg_energy + e, Max48);
        seg_charge = clamp(seg_charge + q, Max48);
        if (seg_count < ssem_pkg::CountMax) seg_count++;
      end
      r.kind = KindSample;
      r.time_ms = rel;
      r.current_ua = 32'(cur);
      r.energy_nj = 48'(e);
      r.charge_ua_ms = 48'(q);
      r.seg_tag = tg;
      r.last = 1'b1;
      pending.push_back(r);
      prev_stamp = stamp;
      prev_cur = cur;
      prev_load = mg;
      seen_first = 1;
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t want;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        mode = ModeSample;
  logic [39:0] stamp_ms = '0;
  logic [24:0] plus_uv = '0;
  logic [24:0] minus_uv = '0;
  logic [7:0]  tag = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        kind;
  logic [39:0] time_ms;
  logic [31:0] current_ua;
  logic [47:0] energy_nj;
  logic [47:0] charge_ua_ms;
  logic [7:0]  seg_tag;
  logic        last;

  meter_scoreboard sb = new();
  int          hold_cnt = 0;
  logic [39:0] run_stamp = '0;
  logic [7:0]  run_tag = '0;

  segmented_shunt_energy_meter_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result('{kind, time_ms, current_ua, energy_nj, charge_ua_ms, seg_tag, last});
        hold_cnt = $urandom_range(0, 3);
        out_stall <= (hold_cnt > 0);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= (hold_cnt > 0);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_request(logic m, logic [39:0] st, logic [24:0] pu, logic [24:0] mu,
                              logic [7:0] tg);
    int gap;
    in_valid <= 1;
    mode <= m;
    stamp_ms <= st;
    plus_uv <= pu;
    minus_uv <= mu;
    tag <= tg;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, st, pu, mu, tg);
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic directed_requests();
    send_request(ModeEnd, '1, '1, '1, '1);
    send_request(ModeSample, '0, 25'h0FFFFFF, 25'h1000000, 8'd0);
    send_request(ModeSample, '1, 25'h1000000, 25'h0FFFFFF, 8'd0);
    send_request(ModeSample, 40'd1000, 25'd5000, 25'd4000, 8'd255);
    send_request(ModeSample, 40'd1010, 25'd5000, 25'd4000, 8'd255);
    send_request(ModeSample, 40'd0, 25'h1FFFFFF, 25'd1, 8'd255);
    send_request(ModeSample, 40'd20, '0, '0, 8'd7);
    send_request(ModeEnd, '0, '0, '0, '0);
    send_request(ModeEnd, '0, '0, '0, '0);
    send_request(ModeSample, 40'h8000000000, 25'd30000, 25'd20000, 8'd1);
    send_request(ModeEnd, '0, '0, '0, '0);
  endtask

  task automatic random_requests(int count);
    logic [24:0] pu, mu;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pu = 25'($urandom);
        mu = 25'($urandom);
      end else begin
        mu = 25'($urandom_range(0, 100000) - 50000);
        pu = 25'(mu + $urandom_range(0, 20000));
      end
      if (pick < 5) begin
        send_request(ModeEnd, 40'({$urandom, $urandom}), pu, mu, 8'($urandom));
      end else begin
        if (pick < 8) run_stamp = 40'({$urandom, $urandom});
        else run_stamp = run_stamp + 40'($urandom_range(0, 2000));
        if ($urandom_range(0, 9) == 0)
          run_tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        send_request(ModeSample, run_stamp, pu, mu, run_tag);
      end
    end
  endtask

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_requests();
    random_requests(300);
    wait_drained();
    write_reg(ssem_pkg::RegPlusGain, '1);
    write_reg(ssem_pkg::RegMinusGain, '1);
    write_reg(ssem_pkg::RegShunt, 18'd1);
    directed_requests();
    random_requests(300);
    wait_drained();
    write_reg(ssem_pkg::RegPlusGain, '0);
    write_reg(ssem_pkg::RegMinusGain, '0);
    write_reg(ssem_pkg::RegShunt, 18'd0);
    random_requests(150);
    wait_drained();
    write_reg(ssem_pkg::RegPlusGain, 18'd1);
    write_reg(ssem_pkg::RegMinusGain, 18'd65536);
    write_reg(ssem_pkg::RegShunt, 18'd65535);
    random_requests(300);
    wait_drained();
    write_reg(ssem_pkg::RegPlusGain, 18'($urandom));
    write_reg(ssem_pkg::RegMinusGain, 18'($urandom));
    write_reg(ssem_pkg::RegShunt, 18'($urandom_range(1, 65535)));
    directed_requests();
    random_requests(400);
    send_request(ModeEnd, '0, '0, '0, '0);
    wait_drained();
    if (sb.pending.size() != 0) sb.errors++;
    $display("covered %0d requests under five register settings,", sb.requests);
    $display("%0d results of which %0d closed segments", sb.results, sb.closes);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ssem_pkg.sv
rtl/ssem_mul.sv
rtl/ssem_div.sv
rtl/segmented_shunt_energy_meter_top.sv
rtl/ssem_check.sv
tb/tb_segmented_shunt_energy_meter_top.sv
